// ===== rtl/cba_pkg.sv =====
package cba_pkg;

    localparam int unsigned COORD_W = 32;
    localparam int unsigned SEG_W   = 9;
    localparam int unsigned T_BITS  = 24;
    localparam int unsigned DIV_W   = SEG_W + T_BITS;   // numerator and quotient width
    localparam int unsigned ROOT_W  = 33;
    localparam int unsigned RAD_W   = 2 * ROOT_W;
    localparam int unsigned SUM_W   = 48;
    localparam int unsigned LEN_W   = 40;
    localparam int unsigned MUL_W   = 34;
    localparam int unsigned CNT_W   = 6;
    localparam int unsigned STEP_W  = 4;
    localparam logic [SEG_W-1:0]  SEG_MAX     = 9'd256;
    localparam logic [SEG_W-1:0]  SEG_RESET   = 9'd20;
    localparam logic [CNT_W-1:0]  DIV_STEPS   = 6'd33;
    localparam logic [CNT_W-1:0]  SQRT_STEPS  = 6'd33;
    localparam logic [STEP_W-1:0] LERP_LAST   = 4'd11;
    localparam logic [STEP_W-1:0] LERP_PER_AX = 4'd6;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_INIT,
        ST_DIV,
        ST_SEG_INIT,
        ST_LERP_MUL,
        ST_LERP_ADD,
        ST_SQ_X,
        ST_SQ_Y,
        ST_SQ_SUM,
        ST_SQRT,
        ST_ACCUM,
        ST_EMIT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_SEG_INIT,
        OP_LERP_MUL,
        OP_LERP_ADD,
        OP_SQ_X,
        OP_SQ_Y,
        OP_SQ_SUM,
        OP_SQRT_STEP,
        OP_ACCUM,
        OP_EMIT
    } op_t;

    typedef struct packed {
        op_t              op;
        logic             axis;      // 0 x, 1 y
        logic [1:0]       pos;       // lower index of the interpolated pair
        logic [SEG_W-1:0] seg_idx;
        logic [SEG_W-1:0] seg_cnt;
    } cmd_t;

    typedef struct packed {
        logic out_busy;
    } status_t;

    // in-place de casteljau order within one axis: 0,1,2 then 0,1 then 0
    function automatic logic [1:0] lerp_pos(input logic [STEP_W-1:0] j);
        logic [1:0] p;
        case (j)
            4'd1:    p = 2'd1;
            4'd2:    p = 2'd2;
            4'd4:    p = 2'd1;
            default: p = 2'd0;
        endcase
        return p;
    endfunction

endpackage

// ===== rtl/cubic_bezier_arc_length_top.sv =====
// channel   direction  handshake           payload
// s_        in         s_valid / s_ready   four control points, signed q16.16 x and y
// m_        out        m_valid / m_ready   m_arc_length (q24.16), m_length_saturated
// cfg_      in         cfg_wr_en           cfg_wr_data: segment count, no wait
//
// one request runs, for each of its n segments, the 33-step t divider, the
// twelve interpolations, each a multiply state then an add state, on the one shared
// multiplier and the 33-step square root, all run one after another
// aresetn is synchronous, active low; segment count resets to 20
// a new request is taken while the previous result still waits on m_ready
// a stalled result holds the controller in its emit state until taken
module cubic_bezier_arc_length_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [cba_pkg::SEG_W-1:0]         cfg_wr_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [cba_pkg::COORD_W-1:0] s_start_x,
    input  logic signed [cba_pkg::COORD_W-1:0] s_start_y,
    input  logic signed [cba_pkg::COORD_W-1:0] s_ctrl1_x,
    input  logic signed [cba_pkg::COORD_W-1:0] s_ctrl1_y,
    input  logic signed [cba_pkg::COORD_W-1:0] s_ctrl2_x,
    input  logic signed [cba_pkg::COORD_W-1:0] s_ctrl2_y,
    input  logic signed [cba_pkg::COORD_W-1:0] s_end_x,
    input  logic signed [cba_pkg::COORD_W-1:0] s_end_y,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [cba_pkg::LEN_W-1:0]         m_arc_length,
    output logic                              m_length_saturated
);

    // command from controller to datapath, output stall back
    cba_pkg::cmd_t    cmd;
    cba_pkg::status_t status;

    // sequencer: segment loop, divider and root step counts, emit wait
    cba_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .status      (status),
        .cmd         (cmd)
    );

    // arithmetic: divider, shared multiplier, square root, sum and result register
    cba_datapath u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .status             (status),
        .s_start_x          (s_start_x),
        .s_start_y          (s_start_y),
        .s_ctrl1_x          (s_ctrl1_x),
        .s_ctrl1_y          (s_ctrl1_y),
        .s_ctrl2_x          (s_ctrl2_x),
        .s_ctrl2_y          (s_ctrl2_y),
        .s_end_x            (s_end_x),
        .s_end_y            (s_end_y),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_arc_length       (m_arc_length),
        .m_length_saturated (m_length_saturated)
    );

endmodule

// ===== rtl/cba_ctrl.sv =====
module cba_ctrl (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [cba_pkg::SEG_W-1:0]  cfg_wr_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  cba_pkg::status_t           status,
    output cba_pkg::cmd_t              cmd
);

    cba_pkg::state_t state_reg, state_next;
    logic [cba_pkg::SEG_W-1:0]  cfg_reg;
    logic [cba_pkg::SEG_W-1:0]  n_reg, n_next;
    logic [cba_pkg::SEG_W-1:0]  i_reg, i_next;
    logic [cba_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [cba_pkg::STEP_W-1:0] k_reg, k_next;
    logic [cba_pkg::STEP_W-1:0] k_in_axis;
    logic [cba_pkg::SEG_W-1:0]  n_eff;

    always_comb begin
        if (cfg_reg == '0) begin
            n_eff = cba_pkg::SEG_W'(1);
        end else if (cfg_reg > cba_pkg::SEG_MAX) begin
            n_eff = cba_pkg::SEG_MAX;
        end else begin
            n_eff = cfg_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg   <= cba_pkg::SEG_RESET;
            state_reg <= cba_pkg::ST_IDLE;
            n_reg     <= '0;
            i_reg     <= '0;
            cnt_reg   <= '0;
            k_reg     <= '0;
        end else begin
            if (cfg_wr_en) begin
                cfg_reg <= cfg_wr_data;
            end
            state_reg <= state_next;
            n_reg     <= n_next;
            i_reg     <= i_next;
            cnt_reg   <= cnt_next;
            k_reg     <= k_next;
        end
    end

    assign k_in_axis = (k_reg >= cba_pkg::LERP_PER_AX) ? k_reg - cba_pkg::LERP_PER_AX : k_reg;

    always_comb begin
        state_next  = state_reg;
        n_next      = n_reg;
        i_next      = i_reg;
        cnt_next    = cnt_reg;
        k_next      = k_reg;
        s_ready     = 1'b0;
        cmd.op      = cba_pkg::OP_NONE;
        cmd.axis    = (k_reg >= cba_pkg::LERP_PER_AX);
        cmd.pos     = cba_pkg::lerp_pos(k_in_axis);
        cmd.seg_idx = i_reg;
        cmd.seg_cnt = n_reg;
        case (state_reg)
            cba_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op     = cba_pkg::OP_LOAD;
                    n_next     = n_eff;
                    i_next     = cba_pkg::SEG_W'(1);
                    state_next = cba_pkg::ST_DIV_INIT;
                end
            end
            cba_pkg::ST_DIV_INIT: begin
                cmd.op     = cba_pkg::OP_DIV_INIT;
                cnt_next   = '0;
                state_next = cba_pkg::ST_DIV;
            end
            cba_pkg::ST_DIV: begin
                cmd.op   = cba_pkg::OP_DIV_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == cba_pkg::DIV_STEPS - 1'b1) begin
                    state_next = cba_pkg::ST_SEG_INIT;
                end
            end
            cba_pkg::ST_SEG_INIT: begin
                cmd.op     = cba_pkg::OP_SEG_INIT;
                k_next     = '0;
                state_next = cba_pkg::ST_LERP_MUL;
            end
            cba_pkg::ST_LERP_MUL: begin
                cmd.op     = cba_pkg::OP_LERP_MUL;
                state_next = cba_pkg::ST_LERP_ADD;
            end
            cba_pkg::ST_LERP_ADD: begin
                cmd.op = cba_pkg::OP_LERP_ADD;
                k_next = k_reg + 1'b1;
                if (k_reg == cba_pkg::LERP_LAST) begin
                    state_next = cba_pkg::ST_SQ_X;
                end else begin
                    state_next = cba_pkg::ST_LERP_MUL;
                end
            end
            cba_pkg::ST_SQ_X: begin
                cmd.op     = cba_pkg::OP_SQ_X;
                state_next = cba_pkg::ST_SQ_Y;
            end
            cba_pkg::ST_SQ_Y: begin
                cmd.op     = cba_pkg::OP_SQ_Y;
                state_next = cba_pkg::ST_SQ_SUM;
            end
            cba_pkg::ST_SQ_SUM: begin
                cmd.op     = cba_pkg::OP_SQ_SUM;
                cnt_next   = '0;
                state_next = cba_pkg::ST_SQRT;
            end
            cba_pkg::ST_SQRT: begin
                cmd.op   = cba_pkg::OP_SQRT_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == cba_pkg::SQRT_STEPS - 1'b1) begin
                    state_next = cba_pkg::ST_ACCUM;
                end
            end
            cba_pkg::ST_ACCUM: begin
                cmd.op = cba_pkg::OP_ACCUM;
                if (i_reg == n_reg) begin
                    state_next = cba_pkg::ST_EMIT;
                end else begin
                    i_next     = i_reg + 1'b1;
                    state_next = cba_pkg::ST_DIV_INIT;
                end
            end
            cba_pkg::ST_EMIT: begin
                if (!status.out_busy) begin
                    cmd.op     = cba_pkg::OP_EMIT;
                    state_next = cba_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = cba_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/cba_datapath.sv =====
module cba_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  cba_pkg::cmd_t                     cmd,
    output cba_pkg::status_t                  status,
    input  logic signed [cba_pkg::COORD_W-1:0] s_start_x,
    input  logic signed [cba_pkg::COORD_W-1:0] s_start_y,
    input  logic signed [cba_pkg::COORD_W-1:0] s_ctrl1_x,
    input  logic signed [cba_pkg::COORD_W-1:0] s_ctrl1_y,
    input  logic signed [cba_pkg::COORD_W-1:0] s_ctrl2_x,
    input  logic signed [cba_pkg::COORD_W-1:0] s_ctrl2_y,
    input  logic signed [cba_pkg::COORD_W-1:0] s_end_x,
    input  logic signed [cba_pkg::COORD_W-1:0] s_end_y,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [cba_pkg::LEN_W-1:0]         m_arc_length,
    output logic                              m_length_saturated
);

    localparam int unsigned CW = cba_pkg::COORD_W;

    logic signed [CW-1:0] px_reg [4];
    logic signed [CW-1:0] py_reg [4];
    logic signed [CW-1:0] wx_reg [4];
    logic signed [CW-1:0] wy_reg [4];
    logic signed [CW-1:0] xi_reg, yi_reg;

    logic [cba_pkg::DIV_W-1:0]   dq_reg;
    logic [cba_pkg::SEG_W:0]     rem_reg;
    logic signed [2*cba_pkg::MUL_W-1:0] prod_reg;
    logic [cba_pkg::RAD_W-1:0]   sqa_reg;
    logic [cba_pkg::RAD_W-1:0]   rad_reg;
    logic [cba_pkg::ROOT_W-1:0]  root_reg;
    logic [cba_pkg::ROOT_W+1:0]  srem_reg;
    logic [cba_pkg::SUM_W-1:0]   sum_reg;
    logic                        m_valid_reg;
    logic [cba_pkg::LEN_W-1:0]   len_reg;
    logic                        sat_reg;

    logic signed [CW-1:0]   wa, wb;
    logic signed [CW:0]     wdiff;
    logic signed [CW:0]     pdx, pdy;
    logic [CW:0]            adx, ady;
    logic signed [cba_pkg::MUL_W-1:0] ma, mb;
    logic signed [2*cba_pkg::MUL_W-1:0] prod;
    logic signed [2*cba_pkg::MUL_W-1:0] lsh;
    logic signed [CW-1:0]   lres;
    logic [cba_pkg::SEG_W:0] div_r2;
    logic                   div_bit;
    logic [cba_pkg::ROOT_W+3:0] srem_sh, trial;
    logic [cba_pkg::ROOT_W:0]   seg_len;

    always_comb begin
        case (cmd.pos)
            2'd0:    begin wa = cmd.axis ? wy_reg[0] : wx_reg[0];
                           wb = cmd.axis ? wy_reg[1] : wx_reg[1]; end
            2'd1:    begin wa = cmd.axis ? wy_reg[1] : wx_reg[1];
                           wb = cmd.axis ? wy_reg[2] : wx_reg[2]; end
            default: begin wa = cmd.axis ? wy_reg[2] : wx_reg[2];
                           wb = cmd.axis ? wy_reg[3] : wx_reg[3]; end
        endcase
    end

    assign wdiff = {wb[CW-1], wb} - {wa[CW-1], wa};
    assign pdx   = {xi_reg[CW-1], xi_reg} - {wx_reg[0][CW-1], wx_reg[0]};
    assign pdy   = {yi_reg[CW-1], yi_reg} - {wy_reg[0][CW-1], wy_reg[0]};
    assign adx   = pdx[CW] ? (CW+1)'(-pdx) : pdx;
    assign ady   = pdy[CW] ? (CW+1)'(-pdy) : pdy;

    always_comb begin
        case (cmd.op)
            cba_pkg::OP_SQ_X: begin
                ma = $signed({1'b0, adx});
                mb = $signed({1'b0, adx});
            end
            cba_pkg::OP_SQ_Y: begin
                ma = $signed({1'b0, ady});
                mb = $signed({1'b0, ady});
            end
            default: begin
                ma = $signed({wdiff[CW], wdiff});
                mb = $signed({{(cba_pkg::MUL_W-cba_pkg::T_BITS-1){1'b0}},
                              dq_reg[cba_pkg::T_BITS:0]});
            end
        endcase
    end

    assign prod = ma * mb;

    // floor((diff * t + half) / 2^24), always lands between the two points
    assign lsh  = (prod_reg + (2*cba_pkg::MUL_W)'(1 << (cba_pkg::T_BITS - 1)))
                  >>> cba_pkg::T_BITS;
    assign lres = wa + lsh[CW-1:0];

    assign div_r2  = {rem_reg[cba_pkg::SEG_W-1:0], dq_reg[cba_pkg::DIV_W-1]};
    assign div_bit = (div_r2 >= {1'b0, cmd.seg_cnt});

    assign srem_sh = {srem_reg, rad_reg[cba_pkg::RAD_W-1 -: 2]};
    assign trial   = {1'b0, root_reg, 2'b01};
    assign seg_len = ({1'b0, srem_reg} > {3'b0, root_reg}) ? {1'b0, root_reg} + 1'b1
                                                           : {1'b0, root_reg};

    always_ff @(posedge aclk) begin
        case (cmd.op)
            cba_pkg::OP_LOAD: begin
                px_reg[0] <= s_start_x; py_reg[0] <= s_start_y;
                px_reg[1] <= s_ctrl1_x; py_reg[1] <= s_ctrl1_y;
                px_reg[2] <= s_ctrl2_x; py_reg[2] <= s_ctrl2_y;
                px_reg[3] <= s_end_x;   py_reg[3] <= s_end_y;
                xi_reg    <= s_start_x;
                yi_reg    <= s_start_y;
                sum_reg   <= '0;
            end
            cba_pkg::OP_DIV_INIT: begin
                dq_reg  <= {cmd.seg_idx, {cba_pkg::T_BITS{1'b0}}}
                           + cba_pkg::DIV_W'(cmd.seg_cnt >> 1);
                rem_reg <= '0;
            end
            cba_pkg::OP_DIV_STEP: begin
                rem_reg <= div_bit ? div_r2 - {1'b0, cmd.seg_cnt} : div_r2;
                dq_reg  <= {dq_reg[cba_pkg::DIV_W-2:0], div_bit};
            end
            cba_pkg::OP_SEG_INIT: begin
                wx_reg <= px_reg;
                wy_reg <= py_reg;
            end
            cba_pkg::OP_LERP_MUL: begin
                prod_reg <= prod;
            end
            cba_pkg::OP_LERP_ADD: begin
                if (cmd.axis) begin
                    wy_reg[cmd.pos] <= lres;
                end else begin
                    wx_reg[cmd.pos] <= lres;
                end
            end
            cba_pkg::OP_SQ_X: begin
                prod_reg <= prod;
            end
            cba_pkg::OP_SQ_Y: begin
                sqa_reg  <= prod_reg[cba_pkg::RAD_W-1:0];
                prod_reg <= prod;
            end
            cba_pkg::OP_SQ_SUM: begin
                rad_reg  <= sqa_reg + prod_reg[cba_pkg::RAD_W-1:0];
                root_reg <= '0;
                srem_reg <= '0;
            end
            cba_pkg::OP_SQRT_STEP: begin
                rad_reg <= {rad_reg[cba_pkg::RAD_W-3:0], 2'b00};
                if (srem_sh >= trial) begin
                    srem_reg <= (cba_pkg::ROOT_W+2)'(srem_sh - trial);
                    root_reg <= {root_reg[cba_pkg::ROOT_W-2:0], 1'b1};
                end else begin
                    srem_reg <= (cba_pkg::ROOT_W+2)'(srem_sh);
                    root_reg <= {root_reg[cba_pkg::ROOT_W-2:0], 1'b0};
                end
            end
            cba_pkg::OP_ACCUM: begin
                sum_reg <= sum_reg + cba_pkg::SUM_W'(seg_len);
                xi_reg  <= wx_reg[0];
                yi_reg  <= wy_reg[0];
            end
            cba_pkg::OP_EMIT: begin
                if (sum_reg[cba_pkg::SUM_W-1:cba_pkg::LEN_W] != '0) begin
                    len_reg <= '1;
                    sat_reg <= 1'b1;
                end else begin
                    len_reg <= sum_reg[cba_pkg::LEN_W-1:0];
                    sat_reg <= 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.op == cba_pkg::OP_EMIT) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign status.out_busy    = m_valid_reg & ~m_ready;
    assign m_valid            = m_valid_reg;
    assign m_arc_length       = len_reg;
    assign m_length_saturated = sat_reg;

endmodule
